// ----- hdl/dnle_pkg.sv -----
// Shared constants and types for the DNS name label encoder.
// No dependencies; used by the label cell chain and the top level.
package dnle_pkg;

    localparam int MAX_LABEL = 62;
    localparam int LEN_W     = $clog2(MAX_LABEL + 1);
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

    // Control word from the sequencer to the cell chain
    typedef struct packed {
        logic              load;
        logic              shift;
        logic [LEN_W-1:0]  wr_idx;
        logic [BYTE_W-1:0] wr_byte;
    } t_chain_ctl;

endpackage

// ----- hdl/dnle_cell.sv -----
// One byte cell of the label chain: loads a new character or takes its
// neighbor's byte on a shift. Depends on dnle_pkg.
module dnle_cell (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_shift,
    input  logic [dnle_pkg::BYTE_W-1:0] i_wr_byte,
    input  logic [dnle_pkg::BYTE_W-1:0] i_next_byte,
    output logic [dnle_pkg::BYTE_W-1:0] o_byte
);

    logic [dnle_pkg::BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_next_byte;
        end else if (i_load) begin
            r_byte <= i_wr_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- hdl/dnle_chain.sv -----
// Row of MAX_LABEL byte cells holding the current label; the head cell
// feeds the output and each shift moves every byte one cell toward it.
// Depends on dnle_pkg and dnle_cell.
module dnle_chain (
    input  logic                        i_clk,
    input  dnle_pkg::t_chain_ctl        i_ctl,
    output logic [dnle_pkg::BYTE_W-1:0] o_head
);

    logic [dnle_pkg::BYTE_W-1:0] w_cell [dnle_pkg::MAX_LABEL];

    for (genvar g = 0; g < dnle_pkg::MAX_LABEL; g++) begin : g_cell
        logic [dnle_pkg::BYTE_W-1:0] w_next;
        logic                        w_load;

        if (g == dnle_pkg::MAX_LABEL - 1) begin : g_tail
            assign w_next = dnle_pkg::TERM_BYTE;
        end else begin : g_body
            assign w_next = w_cell[g+1];
        end

        assign w_load = i_ctl.load && (i_ctl.wr_idx == dnle_pkg::LEN_W'(g));

        dnle_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_load),
            .i_shift     (i_ctl.shift),
            .i_wr_byte   (i_ctl.wr_byte),
            .i_next_byte (w_next),
            .o_byte      (w_cell[g])
        );
    end

    assign o_head = w_cell[0];

endmodule

// ----- hdl/dns_name_label_encoder.sv -----
// DNS name label encoder: takes a dotted host name one character per word
// and emits DNS wire labels (length byte, label bytes) and a zero
// terminator flagged last, with error set on it for an empty leading or interior
// label or a label longer than 62 bytes. One name is worked on at a time.
// A plain character is taken while idle. A dot closing a label stalls input
// while the length and label bytes go out; an end of name also sends the
// terminator, alone with no pending label. The output port sends one byte
// a cycle unless stalled, as the label drains through the chain to the head.
// Depends on dnle_pkg and dnle_chain.
module dns_name_label_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_name_byte,
    input  logic       i_end_of_name,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_error
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_DATA,
        S_TERM
    } t_state;

    t_state                         r_state;
    logic [dnle_pkg::LEN_W-1:0]     r_len;
    logic                           r_pending;
    logic                           r_name_err;
    logic                           r_started;
    logic                           r_term_after;
    logic                           r_out_valid;
    logic [dnle_pkg::BYTE_W-1:0]    r_out_byte;
    logic                           r_last;
    logic                           r_error;

    logic                           w_out_free;
    logic                           w_emit;
    logic                           w_accept;
    logic                           w_is_dot;
    logic                           w_room;
    logic                           w_item_err;
    logic [dnle_pkg::BYTE_W-1:0]    w_head;
    dnle_pkg::t_chain_ctl           w_ctl;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = w_out_free && (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_is_dot   = (i_name_byte == dnle_pkg::DOT_CHAR);
    assign w_room     = (r_len < dnle_pkg::LEN_W'(dnle_pkg::MAX_LABEL));
    // empty interior label on a dot, or an overlong byte that gets dropped
    assign w_item_err = w_is_dot ? ((r_len == '0) && r_started) : !w_room;

    always_comb begin
        w_ctl.load    = w_accept && !i_end_of_name && !w_is_dot && w_room;
        w_ctl.shift   = (r_state == S_DATA) && w_out_free;
        w_ctl.wr_idx  = r_len;
        w_ctl.wr_byte = i_name_byte;
    end

    dnle_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= '0;
            r_pending    <= 1'b0;
            r_name_err   <= 1'b0;
            r_started    <= 1'b0;
            r_term_after <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_end_of_name) begin
                            r_term_after <= 1'b1;
                            r_state      <= (r_len != '0) ? S_LEN : S_TERM;
                        end else begin
                            // a leading empty label turns into an error once more follows
                            if (r_pending || w_item_err) begin
                                r_name_err <= 1'b1;
                            end
                            r_pending <= w_is_dot && (r_len == '0) && !r_started;
                            if (w_is_dot && (r_len != '0)) begin
                                r_term_after <= 1'b0;
                                r_state      <= S_LEN;
                            end else if (!w_is_dot && w_room) begin
                                r_len <= r_len + dnle_pkg::LEN_W'(1);
                            end
                            r_started <= 1'b1;
                        end
                    end
                end
                S_LEN: begin
                    if (w_out_free) begin
                        r_out_byte  <= {{(dnle_pkg::BYTE_W-dnle_pkg::LEN_W){1'b0}}, r_len};
                        r_last      <= 1'b0;
                        r_error     <= 1'b0;
                        r_state     <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (w_out_free) begin
                        r_out_byte  <= w_head;
                        r_last      <= 1'b0;
                        r_error     <= 1'b0;
                        r_len       <= r_len - dnle_pkg::LEN_W'(1);
                        if (r_len == dnle_pkg::LEN_W'(1)) begin
                            r_state <= r_term_after ? S_TERM : S_IDLE;
                        end
                    end
                end
                S_TERM: begin
                    if (w_out_free) begin
                        r_out_byte  <= dnle_pkg::TERM_BYTE;
                        r_last      <= 1'b1;
                        r_error     <= r_name_err;
                        r_name_err  <= 1'b0;
                        r_pending   <= 1'b0;
                        r_started   <= 1'b0;
                        r_len       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;
    assign o_error     = r_error;

endmodule

// ----- hdl/dnle_checker.sv -----
// Port-level checks for the DNS name label encoder, bound to the top level.
// Depends only on the top level's ports.
module dnle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_end_of_name,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last,
    input logic       o_error
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_last) && $stable(o_error))
        else $error("stalled output word changed");

    a_err_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last)
        else $error("error flag outside the terminator");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_out_byte == 8'h00)
        else $error("terminator byte not zero");

    // end of name always owes at least the terminator
    a_eon_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_end_of_name |=> o_in_stall)
        else $error("input taken right after end of name");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_end_of_name (i_end_of_name),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_last        (o_last),
    .o_error       (o_error)
);
